[design/pps_pkg.sv]
// Shared types and constants for the preemptive priority scheduler.
`default_nettype none
package pps_pkg;
    localparam int PRIO_W  = 8;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 32;
    localparam int ID_W    = 6;

    localparam logic MODE_ARRIVAL = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] rem;
        logic [TIME_W-1:0]  arr;
        logic               resp;
        logic [TIME_W-1:0]  order;
    } t_entry;
endpackage
`default_nettype wire

[design/preemptive_priority_scheduler.sv]
// Top level of the preemptive priority scheduler.
// Pulse i_start with an item while o_busy is low. An arrival's result appears on the next
// cycle and o_busy stays low. A tick reads the running entry (skipped when the processor is
// idle), scans all MAX_PROCS table entries through the single table read port, then decides
// and writes back: o_busy is high from the tick until the write-back is done. Each result is
// shown for one cycle with o_valid high and cannot be stalled.
`default_nettype none
module preemptive_priority_scheduler #(
    parameter int MAX_PROCS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_mode,
    input  wire logic [5:0]  i_process_id,
    input  wire logic [7:0]  i_priority_level,
    input  wire logic [15:0] i_burst_length,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_data,
    output logic             o_valid,
    output logic             o_finished,
    output logic [5:0]       o_finished_id,
    output logic [31:0]      o_turnaround_time,
    output logic [31:0]      o_waiting_time,
    output logic             o_dispatched,
    output logic [5:0]       o_dispatched_id,
    output logic             o_first_response,
    output logic [31:0]      o_response_time,
    output logic             o_preempted,
    output logic [31:0]      o_switch_total,
    output logic [31:0]      o_current_time,
    output logic             o_dropped
);
    import pps_pkg::*;

    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int XW = (IW > ID_W) ? IW : ID_W;
    localparam logic [CW-1:0] LAST = CW'(MAX_PROCS);
    localparam logic [XW:0]   NPROC_X = (XW+1)'(MAX_PROCS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;

    logic [2:0]           r_state;
    logic [7:0]           r_cost;
    logic [31:0]          r_now;
    logic [31:0]          r_sw;
    logic [31:0]          r_ocnt;
    logic [7:0]           r_stall;
    logic                 r_run_v;
    logic [IW-1:0]        r_run_id;
    t_entry               r_run;
    logic [MAX_PROCS-1:0] r_active;
    logic [MAX_PROCS-1:0] r_ready;
    logic [CW-1:0]        r_idx;
    logic                 r_pv;
    logic [IW-1:0]        r_pidx;
    logic                 r_bv;
    logic [IW-1:0]        r_bidx;
    t_entry               r_bent;
    logic [31:0]          r_bage;
    logic                 r_fin;
    logic [IW-1:0]        r_fin_id;
    logic [31:0]          r_ta;
    logic [31:0]          r_wt;

    t_entry        rd;
    t_entry        wdata;
    logic          we;
    logic [IW-1:0] waddr;
    logic [IW-1:0] raddr;
    logic [XW-1:0] id_x;
    logic [IW-1:0] id_a;
    logic          accept;
    logic          arr_ok;
    logic [31:0]   age;
    logic          better;
    logic          n_disp;
    logic          n_pre;
    t_entry        n_run;
    t_entry        n_wb;
    logic [IW-1:0] n_run_id;
    logic [7:0]    n_stall;
    logic          n_dec;
    logic [XW-1:0] best_x;
    logic [XW-1:0] fin_x;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && !o_busy;
    assign id_x   = XW'(i_process_id);
    assign id_a   = id_x[IW-1:0];
    assign arr_ok = ({1'b0, id_x} < NPROC_X) && !r_active[id_a];
    assign age    = r_ocnt - rd.order;
    assign better = !r_bv || (rd.prio < r_bent.prio)
                    || ((rd.prio == r_bent.prio) && (age > r_bage));
    assign best_x = XW'(r_bidx);
    assign fin_x  = XW'(r_fin_id);

    always_comb begin
        n_disp   = r_bv && (!r_run_v || (r_bent.prio < r_run.prio));
        n_pre    = n_disp && r_run_v;
        n_run    = n_disp ? r_bent : r_run;
        n_run_id = n_disp ? r_bidx : r_run_id;
        n_stall  = n_disp ? (n_pre ? r_cost : 8'd0) : r_stall;
        n_dec    = (r_run_v || n_disp) && (n_run.rem != '0) && (n_stall == 8'd0);
        n_wb      = n_run;
        n_wb.resp = 1'b1;
        n_wb.rem  = n_dec ? (n_run.rem - BURST_W'(1)) : n_run.rem;
    end

    always_comb begin
        raddr = r_idx[IW-1:0];
        if (r_state == S_IDLE) begin
            raddr = r_run_id;
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_run_id;
        wdata = r_run;
        unique case (r_state)
            S_IDLE: begin
                we          = accept && (i_mode == MODE_ARRIVAL) && arr_ok;
                waddr       = id_a;
                wdata.prio  = i_priority_level;
                wdata.burst = i_burst_length;
                wdata.rem   = i_burst_length;
                wdata.arr   = r_now;
                wdata.resp  = 1'b0;
                wdata.order = r_ocnt;
            end
            S_DEC: begin
                we          = n_pre;
                wdata.order = r_ocnt;
            end
            S_WB: begin
                we = r_run_v;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    pps_table #(
        .DEPTH (MAX_PROCS),
        .AW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cost   <= '0;
            r_now    <= '0;
            r_sw     <= '0;
            r_ocnt   <= '0;
            r_stall  <= '0;
            r_run_v  <= 1'b0;
            r_run_id <= '0;
            r_active <= '0;
            r_ready  <= '0;
            r_idx    <= '0;
            r_pv     <= 1'b0;
            r_bv     <= 1'b0;
            r_fin    <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_cost <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    r_pv  <= 1'b0;
                    r_bv  <= 1'b0;
                    r_fin <= 1'b0;
                    if (accept && (i_mode == MODE_ARRIVAL)) begin
                        o_valid           <= 1'b1;
                        o_finished        <= 1'b0;
                        o_finished_id     <= '0;
                        o_turnaround_time <= '0;
                        o_waiting_time    <= '0;
                        o_dispatched      <= 1'b0;
                        o_dispatched_id   <= '0;
                        o_first_response  <= 1'b0;
                        o_response_time   <= '0;
                        o_preempted       <= 1'b0;
                        o_switch_total    <= r_sw;
                        o_current_time    <= r_now;
                        o_dropped         <= !arr_ok;
                        if (arr_ok) begin
                            r_active[id_a] <= 1'b1;
                            r_ready[id_a]  <= 1'b1;
                            r_ocnt         <= r_ocnt + 32'd1;
                        end
                    end else if (accept) begin
                        r_state <= r_run_v ? S_RUN : S_SCAN;
                    end
                end
                S_RUN: begin
                    r_run <= rd;
                    if (rd.rem == '0) begin
                        r_fin              <= 1'b1;
                        r_fin_id           <= r_run_id;
                        r_ta               <= r_now - rd.arr;
                        r_wt               <= r_now - rd.arr - 32'(rd.burst);
                        r_active[r_run_id] <= 1'b0;
                        r_run_v            <= 1'b0;
                    end
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_pv && better) begin
                        r_bv   <= 1'b1;
                        r_bidx <= r_pidx;
                        r_bent <= rd;
                        r_bage <= age;
                    end
                    if (r_idx == LAST) begin
                        r_pv    <= 1'b0;
                        r_state <= S_DEC;
                    end else begin
                        r_pv   <= r_ready[r_idx[IW-1:0]];
                        r_pidx <= r_idx[IW-1:0];
                        r_idx  <= r_idx + CW'(1);
                    end
                end
                S_DEC: begin
                    o_valid           <= 1'b1;
                    o_finished        <= r_fin;
                    o_finished_id     <= r_fin ? fin_x[ID_W-1:0] : '0;
                    o_turnaround_time <= r_fin ? r_ta : '0;
                    o_waiting_time    <= r_fin ? r_wt : '0;
                    o_dispatched      <= n_disp;
                    o_dispatched_id   <= n_disp ? best_x[ID_W-1:0] : '0;
                    o_first_response  <= n_disp && !r_bent.resp;
                    o_response_time   <= (n_disp && !r_bent.resp) ? (r_now - r_bent.arr) : '0;
                    o_preempted       <= n_pre;
                    o_switch_total    <= r_sw + 32'(n_pre);
                    o_current_time    <= r_now;
                    o_dropped         <= 1'b0;
                    if (n_disp) begin
                        r_ready[r_bidx] <= 1'b0;
                    end
                    if (n_pre) begin
                        r_ready[r_run_id] <= 1'b1;
                        r_ocnt            <= r_ocnt + 32'd1;
                        r_sw              <= r_sw + 32'd1;
                    end
                    r_run          <= n_wb;
                    r_run_id       <= n_run_id;
                    r_run_v        <= r_run_v || n_disp;
                    r_stall        <= (n_stall != 8'd0) ? (n_stall - 8'd1) : 8'd0;
                    r_now          <= r_now + 32'd1;
                    r_state        <= S_WB;
                end
                S_WB: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_run_v) |-> r_active[r_run_id])
        else $error("running process is not active");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_run_v) |-> !r_ready[r_run_id])
        else $error("running process still in ready set");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ready & ~r_active) == '0)
        else $error("ready process is not active");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_preempted) |-> o_dispatched)
        else $error("preemption without dispatch");
endmodule
`default_nettype wire

[design/pps_table.sv]
// Per-process table memory, one write and one registered read port.
`default_nettype none
module pps_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  pps_pkg::t_entry      i_wdata,
    input  wire logic [AW-1:0]   i_raddr,
    output pps_pkg::t_entry      o_rdata
);
    import pps_pkg::*;

    t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
